// ----- hw/rtl/vt100_pkg.sv -----
// shared constants and glyph function for the vt100 escape parser
`timescale 1ns / 1ps
package vt100_pkg;

  localparam logic [1:0] MODE_REGULAR = 2'd0;
  localparam logic [1:0] MODE_ESCAPE  = 2'd1;
  localparam logic [1:0] MODE_CSI     = 2'd2;

  localparam logic [4:0] ACT_NONE     = 5'd0;
  localparam logic [4:0] ACT_PRINT    = 5'd1;
  localparam logic [4:0] ACT_GLYPH    = 5'd2;
  localparam logic [4:0] ACT_BS       = 5'd3;
  localparam logic [4:0] ACT_TAB      = 5'd4;
  localparam logic [4:0] ACT_NEWLINE  = 5'd5;
  localparam logic [4:0] ACT_UP       = 5'd6;
  localparam logic [4:0] ACT_DOWN     = 5'd7;
  localparam logic [4:0] ACT_RIGHT    = 5'd8;
  localparam logic [4:0] ACT_LEFT     = 5'd9;
  localparam logic [4:0] ACT_POS      = 5'd10;
  localparam logic [4:0] ACT_ERASE_D  = 5'd11;
  localparam logic [4:0] ACT_ERASE_L  = 5'd12;
  localparam logic [4:0] ACT_INDEX    = 5'd13;
  localparam logic [4:0] ACT_RINDEX   = 5'd14;
  localparam logic [4:0] ACT_SAVE     = 5'd15;
  localparam logic [4:0] ACT_RESTORE  = 5'd16;
  localparam logic [4:0] ACT_IDENT    = 5'd17;
  localparam logic [4:0] ACT_STAT_OK  = 5'd18;
  localparam logic [4:0] ACT_POS_REP  = 5'd19;
  localparam logic [4:0] ACT_COLORS   = 5'd20;

  localparam logic [3:0] FG_RESET = 4'd15;
  localparam logic [3:0] BG_RESET = 4'd4;

  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7E;

  // block glyph patterns, zero for bytes with no glyph
  function automatic logic [15:0] glyph_of(input logic [7:0] b);
    logic [15:0] g;
    case (b)
      8'd176:  g = 16'h280A;
      8'd177:  g = 16'h5555;
      8'd178:  g = 16'h7D5F;
      8'd220:  g = 16'h6318;
      8'd221:  g = 16'h03FF;
      8'd222:  g = 16'hEC00;
      8'd223:  g = 16'h1CE7;
      default: g = 16'h0000;
    endcase
    return g;
  endfunction

endpackage

// ----- hw/rtl/vt100_ram.sv -----
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
module vt100_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hw/rtl/vt100_escape_parser.sv -----
// vt100 escape parser: one byte in, one decoded display action out
//
// usage: in_byte_i arrives on a valid/ready channel, each beat yields exactly
// one result beat on the output channel (action, args, char, glyph, colors).
// the parameter list lives in a synchronous ram with registered read.
// each byte goes through the steps read slot 0, read slot 1, read slot at the
// index, decode, move to the output register; an sgr final byte also walks
// the stored parameters from last to first through the ram read port before
// the move. one byte is worked on at a time, so a new beat is not taken until
// the last one is through; in_ready_o rises again once the result sits in the
// output register.
// the output register holds its beat until out_ready_i; a stalled receiver
// lets one more byte in, which then waits decoded until the register frees.
// after reset: regular mode, index zero, colors white on blue; the ram is
// not cleared, instead a valid bit per slot makes unwritten slots read zero.
`timescale 1ns / 1ps
module vt100_escape_parser #(
  parameter int MAX_PARAMS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  action_o,
  output logic [15:0] first_arg_o,
  output logic [15:0] second_arg_o,
  output logic [7:0]  char_code_o,
  output logic [15:0] glyph_bits_o,
  output logic [3:0]  fg_color_o,
  output logic [3:0]  bg_color_o
);
  import vt100_pkg::*;

  localparam int AW = $clog2(MAX_PARAMS + 1);
  localparam int RW = $clog2(MAX_PARAMS);
  localparam logic [AW-1:0] MAXP = AW'(MAX_PARAMS);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_P0    = 3'd1; // read slot 0
  localparam logic [2:0] S_P1    = 3'd2; // slot 0 data back, read slot 1
  localparam logic [2:0] S_P2    = 3'd6; // slot 1 data back, read slot at index
  localparam logic [2:0] S_EXEC  = 3'd3; // decode with p0, p1, p[idx]
  localparam logic [2:0] S_SGR   = 3'd4; // walk sgr list
  localparam logic [2:0] S_OUT   = 3'd5; // wait for output register

  logic [2:0]      state_q, state_d;
  logic [7:0]      byte_q;
  logic [1:0]      mode_q, mode_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [7:0]      inter_q, inter_d;
  logic [3:0]      fg_q, fg_d, bg_q, bg_d;
  logic [15:0]     p0_q, p1_q;
  logic [MAX_PARAMS-1:0] vld_q, vld_d;
  logic [AW-1:0]   cnt_q, cnt_d;      // sgr slots left
  logic            sgr_rd_q;          // ram data valid in sgr walk

  // ram
  logic            we;
  logic [RW-1:0]   waddr, raddr;
  logic [15:0]     wdata, rdata, rval;
  logic [RW-1:0]   raddr_q;

  vt100_ram #(.Width(16), .Depth(MAX_PARAMS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // unwritten slots read as zero
  assign rval = vld_q[raddr_q] ? rdata : 16'd0;

  // decoded result, then the output register
  logic        ov_q;
  logic [4:0]  act_q, act_d;
  logic [15:0] a1_q, a1_d, a2_q, a2_d, gl_q, gl_d;
  logic [7:0]  ch_q, ch_d;
  logic        load_out;
  logic [4:0]  res_act_q;
  logic [15:0] res_a1_q, res_a2_q, res_gl_q;
  logic [7:0]  res_ch_q;
  logic [3:0]  res_fg_q, res_bg_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o  = ov_q;
  assign action_o     = res_act_q;
  assign first_arg_o  = res_a1_q;
  assign second_arg_o = res_a2_q;
  assign char_code_o  = res_ch_q;
  assign glyph_bits_o = res_gl_q;
  assign fg_color_o   = res_fg_q;
  assign bg_color_o   = res_bg_q;

  logic out_free;
  assign out_free = !ov_q || out_ready_i;

  // byte classes
  logic is_digit, is_final, is_ctrl_none;
  assign is_digit = byte_q >= DIGIT_LO && byte_q <= DIGIT_HI;
  assign is_final = byte_q >= FINAL_LO && byte_q <= FINAL_HI;

  // slot at current index for digit update
  logic [RW-1:0] idx_slot;
  assign idx_slot = idx_q[RW-1:0];

  // slot at the index is on the ram output during S_EXEC
  logic [19:0] mul10;
  assign mul10 = {1'b0, rval, 3'b000} + {2'b00, rval, 1'b0}
               + {12'd0, byte_q - DIGIT_LO};

  logic [AW-1:0] count;
  assign count = (idx_q >= MAXP) ? MAXP : idx_q + AW'(1);

  always_comb begin
    is_ctrl_none = 1'b0;
    case (byte_q)
      8'h00, 8'h05, 8'h07, 8'h0A, 8'h0B, 8'h0C, 8'h0E, 8'h0F,
      8'h11, 8'h13, 8'h7F: is_ctrl_none = 1'b1;
      default: is_ctrl_none = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    mode_d = mode_q; idx_d = idx_q; inter_d = inter_q;
    fg_d = fg_q; bg_d = bg_q; vld_d = vld_q; cnt_d = cnt_q;
    act_d = act_q; a1_d = a1_q; a2_d = a2_q; ch_d = ch_q; gl_d = gl_q;
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = raddr_q;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        state_d = S_P0;
      end
      S_P0: begin
        raddr = '0; state_d = S_P1;
      end
      S_P1: begin
        raddr = RW'(1); state_d = S_P2;
      end
      S_P2: begin
        raddr = (idx_q < MAXP) ? idx_slot : '0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        act_d = ACT_NONE; a1_d = '0; a2_d = '0; ch_d = '0; gl_d = '0;
        state_d = S_OUT;
        if (byte_q == 8'h08) act_d = ACT_BS;
        else if (byte_q == 8'h09) act_d = ACT_TAB;
        else if (byte_q == 8'h0D) act_d = ACT_NEWLINE;
        else if (is_ctrl_none) act_d = ACT_NONE;
        else if (byte_q == 8'h1B || byte_q == 8'h18 || byte_q == 8'h1A) begin
          inter_d = '0; idx_d = '0;
          we = 1'b1; waddr = '0; wdata = '0; vld_d[0] = 1'b1;
          mode_d = (byte_q == 8'h1B) ? MODE_ESCAPE : MODE_REGULAR;
        end else if (mode_q == MODE_ESCAPE) begin
          if (byte_q >= DIGIT_LO && byte_q <= FINAL_HI) begin
            case (byte_q)
              8'h37: act_d = ACT_SAVE;
              8'h38: if (inter_q != 8'h23) act_d = ACT_RESTORE;
              8'h44: act_d = ACT_INDEX;
              8'h45: act_d = ACT_NEWLINE;
              8'h4D: act_d = ACT_RINDEX;
              8'h5A: act_d = ACT_IDENT;
              default: act_d = ACT_NONE;
            endcase
            mode_d = (byte_q == 8'h5B) ? MODE_CSI : MODE_REGULAR;
            inter_d = '0;
          end else if (inter_q == 8'h00) begin
            inter_d = byte_q;
          end
        end else if (mode_q == MODE_CSI) begin
          if (is_digit) begin
            if (idx_q < MAXP) begin
              we = 1'b1; waddr = idx_slot; wdata = mul10[15:0];
              vld_d[idx_slot] = 1'b1;
            end
          end else if (byte_q == 8'h3B) begin
            if (idx_q < MAXP) begin
              idx_d = idx_q + AW'(1);
              if (idx_q + AW'(1) < MAXP) begin
                we = 1'b1; waddr = RW'(idx_q + AW'(1)); wdata = '0;
                vld_d[RW'(idx_q + AW'(1))] = 1'b1;
              end
            end
          end else if (is_final) begin
            case (byte_q)
              8'h41: begin act_d = ACT_UP;    a1_d = (p0_q != 0) ? p0_q : 16'd1; end
              8'h42: begin act_d = ACT_DOWN;  a1_d = (p0_q != 0) ? p0_q : 16'd1; end
              8'h43: begin act_d = ACT_RIGHT; a1_d = (p0_q != 0) ? p0_q : 16'd1; end
              8'h44: begin act_d = ACT_LEFT;  a1_d = (p0_q != 0) ? p0_q : 16'd1; end
              8'h48, 8'h66: begin
                act_d = ACT_POS;
                a1_d = (p0_q != 0) ? p0_q - 16'd1 : 16'd0;
                if (count >= AW'(2) && p1_q != 0) a2_d = p1_q - 16'd1;
              end
              8'h4A: begin act_d = ACT_ERASE_D; a1_d = p0_q; end
              8'h4B: begin act_d = ACT_ERASE_L; a1_d = p0_q; end
              8'h63: act_d = ACT_IDENT;
              8'h6D: act_d = ACT_COLORS;
              8'h6E: begin
                if (p0_q == 16'd5) act_d = ACT_STAT_OK;
                else if (p0_q == 16'd6) act_d = ACT_POS_REP;
              end
              default: act_d = ACT_NONE;
            endcase
            if (byte_q == 8'h6D) begin
              // walk slots count-1 down to 0 before clearing slot 0
              cnt_d = count - AW'(1);
              raddr = RW'(count - AW'(1));
              state_d = S_SGR;
            end else begin
              we = 1'b1; waddr = '0; wdata = '0; vld_d[0] = 1'b1;
            end
            idx_d = '0;
            mode_d = MODE_REGULAR;
          end
        end else begin
          if (byte_q >= 8'h20 && byte_q < 8'h7F) begin
            act_d = ACT_PRINT; ch_d = byte_q;
          end else if (byte_q == 8'd219) begin
            act_d = ACT_PRINT; ch_d = 8'd127;
          end else if (glyph_of(byte_q) != 16'd0) begin
            act_d = ACT_GLYPH; gl_d = glyph_of(byte_q);
          end
        end
      end
      S_SGR: begin
        if (sgr_rd_q) begin
          if (rval == 16'd0) begin fg_d = FG_RESET; bg_d = BG_RESET; end
          else if (rval >= 16'd30 && rval <= 16'd37) fg_d = 4'(rval - 16'd30);
          else if (rval >= 16'd40 && rval <= 16'd47) bg_d = 4'(rval - 16'd40);
          else if (rval >= 16'd90 && rval <= 16'd97) fg_d = 4'(rval - 16'd82);
          else if (rval >= 16'd100 && rval <= 16'd107) bg_d = 4'(rval - 16'd92);
          if (cnt_q == '0) begin
            we = 1'b1; waddr = '0; wdata = '0; vld_d[0] = 1'b1;
            state_d = S_OUT;
          end else begin
            cnt_d = cnt_q - AW'(1);
            raddr = RW'(cnt_q - AW'(1));
          end
        end
      end
      S_OUT: if (out_free) begin
        load_out = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mode_q <= MODE_REGULAR; idx_q <= '0; inter_q <= '0;
      fg_q <= FG_RESET; bg_q <= BG_RESET; vld_q <= '0; cnt_q <= '0;
      sgr_rd_q <= 1'b0; ov_q <= 1'b0; raddr_q <= '0;
    end else begin
      state_q <= state_d; mode_q <= mode_d; idx_q <= idx_d; inter_q <= inter_d;
      fg_q <= fg_d; bg_q <= bg_d; vld_q <= vld_d; cnt_q <= cnt_d;
      raddr_q <= raddr;
      sgr_rd_q <= (state_d == S_SGR);
      if (load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) byte_q <= in_byte_i;
    if (state_q == S_P1) p0_q <= rval;
    if (state_q == S_P2) p1_q <= rval;
    act_q <= act_d; a1_q <= a1_d; a2_q <= a2_d; ch_q <= ch_d; gl_q <= gl_d;
    // output beat only changes when it is taken or the register is empty
    if (load_out) begin
      res_act_q <= act_q; res_a1_q <= a1_q; res_a2_q <= a2_q;
      res_ch_q <= ch_q; res_gl_q <= gl_q;
      res_fg_q <= fg_q; res_bg_q <= bg_q;
    end
  end

  // result only presented from the output stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second byte taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= MAXP)
    else $error("parameter index out of range");
endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the vt100 escape parser
`timescale 1ns / 1ps
module tb;
  import vt100_pkg::*;

  localparam int NPARAM    = 10;
  localparam int N_RANDOM  = 1700;
  localparam int CYC_LIMIT = 400000;

  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] first_arg;
    logic [15:0] second_arg;
    logic [7:0]  char_code;
    logic [15:0] glyph_bits;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
  } decode_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  action_o;
  logic [15:0] first_arg_o, second_arg_o, glyph_bits_o;
  logic [7:0]  char_code_o;
  logic [3:0]  fg_color_o, bg_color_o;

  vt100_escape_parser #(.MAX_PARAMS(NPARAM)) dut (.*);

  // predictor state
  logic [1:0]  mode_q;
  logic [15:0] params_q [NPARAM];
  logic [3:0]  pidx_q;
  logic [7:0]  inter_q;
  logic [3:0]  fg_q, bg_q;

  logic [7:0] byte_queue [$];
  decode_t    expected_q [$];
  int         n_errors = 0;
  int         cycle_cnt = 0;
  bit         stim_done = 0;
  bit         long_hold = 0;
  bit         drain_req = 0;
  bit         accepted_in = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    n_errors++;
  endtask

  function automatic void apply_color(input logic [15:0] p);
    if (p == 0) begin
      fg_q = FG_RESET; bg_q = BG_RESET;
    end else if (p >= 30 && p <= 37) begin
      fg_q = 4'(p - 30);
    end else if (p >= 40 && p <= 47) begin
      bg_q = 4'(p - 40);
    end else if (p >= 90 && p <= 97) begin
      fg_q = 4'(p - 82);
    end else if (p >= 100 && p <= 107) begin
      bg_q = 4'(p - 92);
    end
  endfunction

  function automatic decode_t decode_byte(input logic [7:0] b);
    decode_t r;
    bit ctrl;
    int cnt;
    logic [15:0] p0, n;
    r = '0;
    ctrl = 1;
    case (b)
      8'h00, 8'h05, 8'h07, 8'h0A, 8'h0B, 8'h0C, 8'h0E, 8'h0F, 8'h11, 8'h13, 8'h7F: ;
      8'h08: r.action = ACT_BS;
      8'h09: r.action = ACT_TAB;
      8'h0D: r.action = ACT_NEWLINE;
      8'h1B: begin
        inter_q = 0; pidx_q = 0; params_q[0] = 0; mode_q = MODE_ESCAPE;
      end
      8'h18, 8'h1A: begin
        inter_q = 0; pidx_q = 0; params_q[0] = 0; mode_q = MODE_REGULAR;
      end
      default: ctrl = 0;
    endcase
    if (!ctrl) begin
      if (mode_q == MODE_ESCAPE) begin
        if (b >= DIGIT_LO && b <= FINAL_HI) begin
          case (b)
            "7": r.action = ACT_SAVE;
            "8": if (inter_q != "#") r.action = ACT_RESTORE;
            "D": r.action = ACT_INDEX;
            "E": r.action = ACT_NEWLINE;
            "M": r.action = ACT_RINDEX;
            "Z": r.action = ACT_IDENT;
            default: ;
          endcase
          mode_q = (b == "[") ? MODE_CSI : MODE_REGULAR;
          inter_q = 0;
        end else if (inter_q == 0) begin
          inter_q = b;
        end
      end else if (mode_q == MODE_CSI) begin
        if (b >= DIGIT_LO && b <= DIGIT_HI) begin
          if (pidx_q < NPARAM) params_q[pidx_q] = 16'(params_q[pidx_q] * 10 + (b - 8'h30));
        end else if (b == ";") begin
          if (pidx_q < NPARAM) begin
            pidx_q++;
            if (pidx_q < NPARAM) params_q[pidx_q] = 0;
          end
        end else if (b >= FINAL_LO && b <= FINAL_HI) begin
          cnt = (pidx_q >= NPARAM) ? NPARAM : pidx_q + 1;
          p0 = params_q[0];
          n = (p0 != 0) ? p0 : 16'd1;
          case (b)
            "A": begin r.action = ACT_UP; r.first_arg = n; end
            "B": begin r.action = ACT_DOWN; r.first_arg = n; end
            "C": begin r.action = ACT_RIGHT; r.first_arg = n; end
            "D": begin r.action = ACT_LEFT; r.first_arg = n; end
            "H", "f": begin
              r.action = ACT_POS;
              r.first_arg = (p0 != 0) ? p0 - 16'd1 : 16'd0;
              if (cnt >= 2 && params_q[1] != 0) r.second_arg = params_q[1] - 16'd1;
            end
            "J": begin r.action = ACT_ERASE_D; r.first_arg = p0; end
            "K": begin r.action = ACT_ERASE_L; r.first_arg = p0; end
            "c": r.action = ACT_IDENT;
            "m": begin
              // colors are applied from the last parameter back to the first
              for (int i = cnt - 1; i >= 0; i--) apply_color(params_q[i]);
              r.action = ACT_COLORS;
            end
            "n": begin
              if (p0 == 5) r.action = ACT_STAT_OK;
              else if (p0 == 6) r.action = ACT_POS_REP;
            end
            default: ;
          endcase
          pidx_q = 0; params_q[0] = 0; mode_q = MODE_REGULAR;
        end
      end else begin
        if (b >= 8'h20 && b < 8'h7F) begin
          r.action = ACT_PRINT; r.char_code = b;
        end else if (b == 8'd219) begin
          r.action = ACT_PRINT; r.char_code = 8'd127;
        end else begin
          case (b)
            8'd176: r.glyph_bits = 16'h280A;
            8'd177: r.glyph_bits = 16'h5555;
            8'd178: r.glyph_bits = 16'h7D5F;
            8'd220: r.glyph_bits = 16'h6318;
            8'd221: r.glyph_bits = 16'h03FF;
            8'd222: r.glyph_bits = 16'hEC00;
            8'd223: r.glyph_bits = 16'h1CE7;
            default: ;
          endcase
          if (r.glyph_bits != 0) r.action = ACT_GLYPH;
        end
      end
    end
    r.fg_color = fg_q;
    r.bg_color = bg_q;
    return r;
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
  endtask

  // random number, sometimes huge to exercise 16-bit wrap
  task automatic push_num();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 9);
      1: v = $urandom_range(30, 47);
      2: v = $urandom_range(90, 107);
      3: v = $urandom_range(0, 999);
      4: v = $urandom_range(60000, 99999);
      default: v = $urandom_range(1, 8);
    endcase
    if ($urandom_range(0, 7) != 0) push_str($sformatf("%0d", v));
  endtask

  task automatic push_random_seq();
    int k;
    string finals;
    finals = "ABCDHfJKcmnmmHqz@~";
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        byte_queue.push_back(8'h1B); byte_queue.push_back("[");
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 3);
        for (int i = 0; i < k; i++) begin
          push_num();
          if (i < k - 1) byte_queue.push_back(";");
        end
        if ($urandom_range(0, 9) == 0) byte_queue.push_back(8'($urandom_range(0, 255)));
        byte_queue.push_back(finals[$urandom_range(0, finals.len() - 1)]);
      end
      5: begin
        byte_queue.push_back(8'h1B);
        if ($urandom_range(0, 2) == 0) byte_queue.push_back(8'($urandom_range(8'h20, 8'h2F)));
        byte_queue.push_back(8'($urandom_range(8'h30, 8'h7E)));
      end
      6: begin
        byte_queue.push_back(8'h1B); byte_queue.push_back("[");
        push_num();
        byte_queue.push_back(($urandom_range(0, 1) != 0) ? 8'h18 : 8'h1B);
      end
      default: byte_queue.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // stimulus
  initial begin
    fg_q = FG_RESET; bg_q = BG_RESET;
    mode_q = MODE_REGULAR; pidx_q = 0; inter_q = 0;
    foreach (params_q[i]) params_q[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: controls, print extremes, glyphs, escapes, csi and sgr
    byte_queue.push_back(8'h00); byte_queue.push_back(8'h08);
    byte_queue.push_back(8'h09); byte_queue.push_back(8'h0D);
    byte_queue.push_back(8'h20); byte_queue.push_back(8'h7E);
    byte_queue.push_back(8'd219); byte_queue.push_back(8'd176);
    byte_queue.push_back(8'd223); byte_queue.push_back(8'hFF);
    push_str("\0337\033#8\0338\033D\033E\033M\033Z");
    push_str("\033[5;7H\033[65537A\033[2J\033[?1K");
    push_str("\033[0;1;2;3;4;5;6;7;8;9;10;11m\033[37;100;41;97m\033[6n\033[5n\033[c");
    wait (byte_queue.size() == 0 && !in_valid_i && expected_q.size() == 0);
    // long receiver hold while sender keeps offering
    long_hold = 1;
    for (int i = 0; i < 20; i++) push_random_seq();
    repeat (300) @(posedge clk_i);
    long_hold = 0;
    for (int i = 0; i < N_RANDOM / 5; i++) begin
      push_random_seq();
      if (i == N_RANDOM / 10) begin
        // sender pause until everything is drained
        wait (byte_queue.size() == 0 && !in_valid_i && expected_q.size() == 0);
      end
      wait (byte_queue.size() < 8);
    end
    wait (byte_queue.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // driver: bursts and gaps, changes at falling edge
  int gap_cnt = 0;
  int burst_cnt = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !accepted_in) begin
        // hold current beat
      end else if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid_i <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_byte_i <= byte_queue.pop_front();
        in_valid_i <= 1'b1;
        if (burst_cnt == 0) begin
          burst_cnt <= $urandom_range(1, 30);
          gap_cnt <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 25);
        end else begin
          burst_cnt <= burst_cnt - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= !long_hold && ($urandom_range(0, 3) != 0 || cycle_cnt[9]);
    end
  end

  // monitor: sample at rising edge
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    accepted_in <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) expected_q.push_back(decode_byte(in_byte_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", 32'(action_o), 0);
      end else begin
        decode_t w;
        w = expected_q.pop_front();
        if (action_o !== w.action)
          report("action", 32'(action_o), 32'(w.action));
        if (first_arg_o !== w.first_arg)
          report("first_arg", 32'(first_arg_o), 32'(w.first_arg));
        if (second_arg_o !== w.second_arg)
          report("second_arg", 32'(second_arg_o), 32'(w.second_arg));
        if (char_code_o !== w.char_code)
          report("char_code", 32'(char_code_o), 32'(w.char_code));
        if (glyph_bits_o !== w.glyph_bits)
          report("glyph_bits", 32'(glyph_bits_o), 32'(w.glyph_bits));
        if (fg_color_o !== w.fg_color)
          report("fg_color", 32'(fg_color_o), 32'(w.fg_color));
        if (bg_color_o !== w.bg_color)
          report("bg_color", 32'(bg_color_o), 32'(w.bg_color));
      end
    end
  end
endmodule
